>>> src/izrc_pkg.sv
// Package: shared types, codes and constants of the irrigation zone run controller.
package izrc_pkg;

    localparam int unsigned ZONES     = 8;
    localparam int unsigned ZONE_W    = 3;
    localparam int unsigned MOIST_W   = 10;
    localparam logic [9:0]  MOIST_MAX = 10'd1000;

    localparam logic [2:0] FUNC_TICK     = 3'd0;
    localparam logic [2:0] FUNC_MANUAL   = 3'd1;
    localparam logic [2:0] FUNC_SERVICE  = 3'd2;
    localparam logic [2:0] FUNC_STOP     = 3'd3;
    localparam logic [2:0] FUNC_AUTO     = 3'd4;
    localparam logic [2:0] FUNC_SVC_MODE = 3'd5;
    localparam logic [2:0] FUNC_READING  = 3'd6;

    localparam logic [2:0] RC_OK       = 3'd0;
    localparam logic [2:0] RC_BUSY     = 3'd1;
    localparam logic [2:0] RC_BAD_ZONE = 3'd2;
    localparam logic [2:0] RC_BAD_ARGS = 3'd3;
    localparam logic [2:0] RC_DISABLED = 3'd4;
    localparam logic [2:0] RC_FAULT    = 3'd5;
    localparam logic [2:0] RC_SERVICE  = 3'd6;
    localparam logic [2:0] RC_IDLE     = 3'd7;

    localparam logic [1:0] SRC_NONE    = 2'd0;
    localparam logic [1:0] SRC_MANUAL  = 2'd1;
    localparam logic [1:0] SRC_AUTO    = 2'd2;
    localparam logic [1:0] SRC_SERVICE = 2'd3;

    localparam logic [2:0] CFG_ENABLE  = 3'd0;
    localparam logic [2:0] CFG_AUTOMSK = 3'd1;
    localparam logic [2:0] CFG_TARGET  = 3'd2;
    localparam logic [2:0] CFG_MARGIN  = 3'd3;
    localparam logic [2:0] CFG_MAXDUR  = 3'd4;
    localparam logic [2:0] CFG_AUTODUR = 3'd5;

    typedef struct packed {
        logic [2:0]  func;
        logic [2:0]  zone;
        logic        zone_out_of_range;
        logic [31:0] req_dur_ms;
        logic [15:0] elapsed_ms;
        logic        mode_flag;
        logic [9:0]  moisture_reading;
        logic        fault_flag;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  result_code;
        logic        pump_on;
        logic        active_valid;
        logic [2:0]  active_zone;
        logic [1:0]  run_source;
        logic [31:0] remaining_ms_out;
        logic        run_started;
        logic        run_finished;
        logic [31:0] completed_runs;
        logic        auto_mode_out;
        logic        service_mode_out;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic load;        // capture the input beat
        logic exec;        // run the item's single-step work
        logic scan_clear;  // reset the driest-zone search
        logic scan_step;   // examine zone at scan index
        logic auto_start;  // try start of the selected zone
        logic publish;     // capture the result beat
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_scan;   // tick left idle with auto mode on and service mode off
        logic scan_last;   // scan index at last zone
    } dp_sts_t;

    function automatic logic [9:0] reset_moisture(input int unsigned i);
        int unsigned m;
        m = 380 + 40 * i;
        return (m > 1000) ? MOIST_MAX : m[9:0];
    endfunction

endpackage

>>> src/irrigation_zone_run_controller_unit.sv
// Top level: irrigation zone run controller, controller plus datapath.
//
//  channel | ports                          | direction
//  --------+--------------------------------+----------
//  input   | s_valid s_ready s_data         | in
//  result  | m_valid m_ready m_data         | out
//  config  | cfg_we cfg_index cfg_data      | in
//
// One item at a time: load, execute, then out. A tick that leaves no run
// with auto mode on and service mode off adds a scan over ZONES stored
// zones (one zone a cycle in the datapath's compare unit) plus a start
// step. A result waits in the output register; the next beat is taken
// while it waits, and only the hand-off of the following result stalls.
// aresetn is synchronous, active low; it restores state, config, zone table.
module irrigation_zone_run_controller_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  izrc_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output izrc_pkg::out_item_t m_data,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);
    izrc_pkg::dp_cmd_t cmd;
    izrc_pkg::dp_sts_t sts;

    // sequence each beat
    izrc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // hold state and compute the result
    izrc_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_data    (m_data)
    );
endmodule

>>> src/izrc_ctrl.sv
// Controller: sequences load, execute, zone scan and result hand-off.
module izrc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  izrc_pkg::dp_sts_t   sts,
    output izrc_pkg::dp_cmd_t   cmd
);
    typedef enum logic [2:0] {ST_IDLE, ST_EXEC, ST_SCAN, ST_START, ST_OUT} state_t;
    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec       = 1'b1;
                cmd.scan_clear = 1'b1;
                state_next     = sts.need_scan ? ST_SCAN : ST_OUT;
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                cmd.auto_start = 1'b1;
                state_next     = ST_OUT;
            end
            ST_OUT: begin
                // wait for the previous result to drain
                if (!m_valid_reg || m_ready) begin
                    cmd.publish  = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end
endmodule

>>> src/izrc_datapath.sv
// Datapath: configuration, run state, zone tables and driest-zone search.
module izrc_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  izrc_pkg::in_item_t  s_data,
    input  izrc_pkg::dp_cmd_t   cmd,
    output izrc_pkg::dp_sts_t   sts,
    output izrc_pkg::out_item_t m_data
);
    localparam int unsigned ZN = izrc_pkg::ZONES;
    localparam int unsigned ZW = izrc_pkg::ZONE_W;

    logic [7:0]  en_mask_reg, auto_mask_reg;
    logic [9:0]  target_reg, margin_reg;
    logic [31:0] max_dur_reg, auto_dur_reg;

    izrc_pkg::in_item_t  item_reg;
    izrc_pkg::out_item_t out_reg;

    logic        active_reg, active_next;
    logic [ZW-1:0] zone_reg, zone_next;
    logic [1:0]  src_reg, src_next;
    logic [31:0] left_reg, left_next;
    logic [31:0] done_reg, done_next;
    logic        auto_reg, auto_next;
    logic        svc_reg, svc_next;
    logic        started_reg, started_next;
    logic        finished_reg, finished_next;
    logic [2:0]  code_reg, code_next;

    logic [9:0]  moist_reg [ZN];
    logic [ZN-1:0] fault_reg;
    logic        wr_moist, wr_fault, fault_val;

    logic [ZW-1:0] scan_idx_reg;
    logic          best_ok_reg;
    logic [ZW-1:0] best_idx_reg;
    logic [9:0]    best_val_reg;

    // start check shared by commands and the automatic start
    logic          st_req, st_bad, st_allow;
    logic [ZW-1:0] st_zone;
    logic [31:0]   st_dur;
    logic [1:0]    st_src;
    logic [2:0]    st_code;
    logic          st_en;

    always_comb begin
        st_en = ({29'd0, st_zone} < 32'(8)) ? en_mask_reg[st_zone[2:0]] : 1'b0;
        if (st_bad || ({29'd0, st_zone} >= 32'(ZN))) begin
            st_code = izrc_pkg::RC_BAD_ZONE;
        end else if (!st_en) begin
            st_code = izrc_pkg::RC_DISABLED;
        end else if (fault_reg[st_zone] && !st_allow) begin
            st_code = izrc_pkg::RC_FAULT;
        end else if (st_dur == 32'd0 || st_dur > max_dur_reg) begin
            st_code = izrc_pkg::RC_BAD_ARGS;
        end else if (active_reg && zone_reg != st_zone) begin
            st_code = izrc_pkg::RC_BUSY;
        end else begin
            st_code = izrc_pkg::RC_OK;
        end
    end

    logic [10:0] trigger;   // target - margin, bit 10 = negative
    assign trigger = {1'b0, target_reg} - {1'b0, margin_reg};

    logic scan_elig;
    always_comb begin
        scan_elig = en_mask_reg[scan_idx_reg] && auto_mask_reg[scan_idx_reg]
                    && !fault_reg[scan_idx_reg] && !trigger[10]
                    && ({1'b0, moist_reg[scan_idx_reg]} <= trigger);
    end

    always_comb begin
        active_next   = active_reg;
        zone_next     = zone_reg;
        src_next      = src_reg;
        left_next     = left_reg;
        done_next     = done_reg;
        auto_next     = auto_reg;
        svc_next      = svc_reg;
        started_next  = started_reg;
        finished_next = finished_reg;
        code_next     = code_reg;
        wr_moist      = 1'b0;
        wr_fault      = 1'b0;
        fault_val     = 1'b0;
        st_req        = 1'b0;
        st_bad        = item_reg.zone_out_of_range;
        st_zone       = item_reg.zone;
        st_dur        = item_reg.req_dur_ms;
        st_src        = izrc_pkg::SRC_MANUAL;
        st_allow      = 1'b0;
        sts.need_scan = 1'b0;
        sts.scan_last = (scan_idx_reg == ZW'(ZN - 1));

        if (cmd.exec) begin
            started_next  = 1'b0;
            finished_next = 1'b0;
            code_next     = izrc_pkg::RC_OK;
            case (item_reg.func)
                izrc_pkg::FUNC_TICK: begin
                    if (active_reg) begin
                        if ({16'd0, item_reg.elapsed_ms} >= left_reg) begin
                            active_next = 1'b0; finished_next = 1'b1;
                        end else begin
                            left_next = left_reg - {16'd0, item_reg.elapsed_ms};
                        end
                    end
                    sts.need_scan = auto_reg && !svc_reg &&
                        !(active_reg && ({16'd0, item_reg.elapsed_ms} < left_reg));
                end
                izrc_pkg::FUNC_MANUAL: begin
                    st_req = 1'b1;
                end
                izrc_pkg::FUNC_SERVICE: begin
                    if (svc_reg) begin
                        st_req = 1'b1; st_src = izrc_pkg::SRC_SERVICE; st_allow = 1'b1;
                    end else begin
                        code_next = izrc_pkg::RC_SERVICE;
                    end
                end
                izrc_pkg::FUNC_STOP: begin
                    if (active_reg) begin
                        active_next = 1'b0; finished_next = 1'b1;
                    end else begin
                        code_next = izrc_pkg::RC_IDLE;
                    end
                end
                izrc_pkg::FUNC_AUTO: auto_next = item_reg.mode_flag;
                izrc_pkg::FUNC_SVC_MODE: begin
                    if (svc_reg != item_reg.mode_flag) begin
                        svc_next = item_reg.mode_flag;
                        if (active_reg && (item_reg.mode_flag ||
                                           src_reg == izrc_pkg::SRC_SERVICE)) begin
                            active_next = 1'b0; finished_next = 1'b1;
                        end
                    end
                end
                izrc_pkg::FUNC_READING: begin
                    if (item_reg.zone_out_of_range || ({29'd0, item_reg.zone} >= 32'(ZN))) begin
                        code_next = izrc_pkg::RC_BAD_ZONE;
                    end else if (item_reg.fault_flag) begin
                        wr_fault = 1'b1; fault_val = 1'b1;
                        if (active_reg && zone_reg == item_reg.zone) begin
                            active_next = 1'b0; finished_next = 1'b1;
                        end
                    end else begin
                        wr_fault = 1'b1; wr_moist = 1'b1;
                    end
                end
                default: code_next = izrc_pkg::RC_BAD_ARGS;
            endcase
        end

        if (cmd.auto_start && best_ok_reg) begin
            st_req   = 1'b1;
            st_bad   = 1'b0;
            st_zone  = best_idx_reg;
            st_dur   = auto_dur_reg;
            st_src   = izrc_pkg::SRC_AUTO;
        end

        if (st_req) begin
            code_next = st_code;
            if (st_code == izrc_pkg::RC_OK) begin
                active_next  = 1'b1;
                zone_next    = st_zone;
                left_next    = st_dur;
                src_next     = st_src;
                started_next = 1'b1;
            end
        end

        if (finished_next && cmd.exec) begin
            zone_next = '0; src_next = izrc_pkg::SRC_NONE; left_next = '0;
            done_next = done_reg + 32'd1;
        end
        if (cmd.exec && finished_next && st_req && st_code == izrc_pkg::RC_OK) begin
            zone_next = st_zone; src_next = st_src; left_next = st_dur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            en_mask_reg   <= 8'hFF;
            auto_mask_reg <= 8'hFF;
            target_reg    <= 10'd450;
            margin_reg    <= 10'd50;
            max_dur_reg   <= 32'd600000;
            auto_dur_reg  <= 32'd60000;
            active_reg    <= 1'b0;
            zone_reg      <= '0;
            src_reg       <= izrc_pkg::SRC_NONE;
            left_reg      <= '0;
            done_reg      <= '0;
            auto_reg      <= 1'b0;
            svc_reg       <= 1'b0;
            started_reg   <= 1'b0;
            finished_reg  <= 1'b0;
            code_reg      <= izrc_pkg::RC_OK;
            fault_reg     <= '0;
            for (int i = 0; i < ZN; i++) begin
                moist_reg[i] <= izrc_pkg::reset_moisture(i);
            end
            scan_idx_reg  <= '0;
            best_ok_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    izrc_pkg::CFG_ENABLE:  en_mask_reg   <= cfg_data[7:0];
                    izrc_pkg::CFG_AUTOMSK: auto_mask_reg <= cfg_data[7:0];
                    izrc_pkg::CFG_TARGET:  target_reg    <= cfg_data[9:0];
                    izrc_pkg::CFG_MARGIN:  margin_reg    <= cfg_data[9:0];
                    izrc_pkg::CFG_MAXDUR:  max_dur_reg   <= cfg_data;
                    izrc_pkg::CFG_AUTODUR: auto_dur_reg  <= cfg_data;
                    default: ;
                endcase
            end
            active_reg   <= active_next;
            zone_reg     <= zone_next;
            src_reg      <= src_next;
            left_reg     <= left_next;
            done_reg     <= done_next;
            auto_reg     <= auto_next;
            svc_reg      <= svc_next;
            started_reg  <= started_next;
            finished_reg <= finished_next;
            code_reg     <= code_next;
            if (wr_fault) begin
                fault_reg[item_reg.zone] <= fault_val;
            end
            if (wr_moist) begin
                moist_reg[item_reg.zone] <= (item_reg.moisture_reading > izrc_pkg::MOIST_MAX)
                                            ? izrc_pkg::MOIST_MAX : item_reg.moisture_reading;
            end
            if (cmd.scan_clear) begin
                scan_idx_reg <= '0;
                best_ok_reg  <= 1'b0;
            end else if (cmd.scan_step) begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
                if (scan_elig && (!best_ok_reg || moist_reg[scan_idx_reg] < best_val_reg)) begin
                    best_ok_reg <= 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= s_data;
        end
        if (cmd.scan_step && scan_elig &&
            (!best_ok_reg || moist_reg[scan_idx_reg] < best_val_reg)) begin
            best_idx_reg <= scan_idx_reg;
            best_val_reg <= moist_reg[scan_idx_reg];
        end
        if (cmd.publish) begin
            out_reg.result_code      <= code_reg;
            out_reg.pump_on          <= active_reg;
            out_reg.active_valid     <= active_reg;
            out_reg.active_zone      <= active_reg ? zone_reg : 3'd0;
            out_reg.run_source       <= active_reg ? src_reg : izrc_pkg::SRC_NONE;
            out_reg.remaining_ms_out <= active_reg ? left_reg : 32'd0;
            out_reg.run_started      <= started_reg;
            out_reg.run_finished     <= finished_reg;
            out_reg.completed_runs   <= done_reg;
            out_reg.auto_mode_out    <= auto_reg;
            out_reg.service_mode_out <= svc_reg;
        end
    end

    assign m_data = out_reg;
endmodule

>>> src/izrc_checker.sv
// Checker: port-level properties of the irrigation zone run controller.
module izrc_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input izrc_pkg::out_item_t m_data
);
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat dropped or changed while stalled");
    a_pump_active: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.pump_on == m_data.active_valid)
        else $error("pump and active flag disagree");
    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.active_valid |-> m_data.remaining_ms_out == 32'd0
        && m_data.run_source == izrc_pkg::SRC_NONE)
        else $error("idle result shows run data");
    a_no_double: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second beat taken while busy");
endmodule

bind irrigation_zone_run_controller_unit izrc_checker u_izrc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
